// ----- hdl/mips_signed_divide_hi_lo_assert.svh -----
// Assertion macros used by the divider top level.
`ifndef MIPS_SIGNED_DIVIDE_HI_LO_ASSERT_SVH
`define MIPS_SIGNED_DIVIDE_HI_LO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSHL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSHL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider check failed");

`endif

// ----- hdl/mshl_pkg.sv -----
package mshl_pkg;

    // Operand and result width.
    localparam int unsigned DATA_W = 32;
    // One quotient bit is resolved per step stage.
    localparam int unsigned STEPS = DATA_W;

    // Work carried down the step stages. The dividend magnitude shifts out
    // of the top of dq while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dq;
        logic [DATA_W-1:0] dvs;
        logic              q_neg;
        logic              r_neg;
    } t_div_work;

    function automatic logic [DATA_W-1:0] negate(input logic [DATA_W-1:0] v);
        return DATA_W'(~v + DATA_W'(1));
    endfunction

endpackage

// ----- hdl/mshl_in_if.sv -----
interface mshl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mshl_pkg::DATA_W-1:0]    dividend;
    logic signed [mshl_pkg::DATA_W-1:0]    divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// ----- hdl/mshl_out_if.sv -----
interface mshl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mshl_pkg::DATA_W-1:0]    quot_lo;
    logic signed [mshl_pkg::DATA_W-1:0]    rem_hi;

    modport source (output valid, output quot_lo, output rem_hi, input ready);
    modport sink (input valid, input quot_lo, input rem_hi, output ready);
endinterface

// ----- hdl/mshl_pre.sv -----
module mshl_pre (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [mshl_pkg::DATA_W-1:0]    i_dividend,
    input  logic [mshl_pkg::DATA_W-1:0]    i_divisor,
    output logic                           o_valid,
    output mshl_pkg::t_div_work            o_work
);

    logic                r_valid;
    mshl_pkg::t_div_work r_work;
    mshl_pkg::t_div_work n_work;
    logic                w_a_neg;
    logic                w_b_neg;

    assign w_a_neg = i_dividend[mshl_pkg::DATA_W-1];
    assign w_b_neg = i_divisor[mshl_pkg::DATA_W-1];

    always_comb begin
        n_work.rem   = '0;
        n_work.dq    = w_a_neg ? mshl_pkg::negate(i_dividend) : i_dividend;
        n_work.dvs   = w_b_neg ? mshl_pkg::negate(i_divisor) : i_divisor;
        n_work.q_neg = w_a_neg ^ w_b_neg;
        n_work.r_neg = w_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ----- hdl/mshl_step.sv -----
module mshl_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  mshl_pkg::t_div_work i_work,
    output logic                o_valid,
    output mshl_pkg::t_div_work o_work
);

    logic                        r_valid;
    mshl_pkg::t_div_work         r_work;
    mshl_pkg::t_div_work         n_work;
    logic [mshl_pkg::DATA_W:0]   w_shift;
    logic [mshl_pkg::DATA_W:0]   w_diff;
    logic                        w_fits;

    // Restoring step: bring down the next dividend bit and try the subtract.
    assign w_shift = {i_work.rem, i_work.dq[mshl_pkg::DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, i_work.dvs};
    assign w_fits  = !w_diff[mshl_pkg::DATA_W];

    always_comb begin
        n_work     = i_work;
        n_work.rem = w_fits ? w_diff[mshl_pkg::DATA_W-1:0] : w_shift[mshl_pkg::DATA_W-1:0];
        n_work.dq  = {i_work.dq[mshl_pkg::DATA_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ----- hdl/mshl_post.sv -----
module mshl_post (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  mshl_pkg::t_div_work            i_work,
    output logic                           o_valid,
    output logic [mshl_pkg::DATA_W-1:0]    o_lo,
    output logic [mshl_pkg::DATA_W-1:0]    o_hi
);

    logic                        r_valid;
    logic [mshl_pkg::DATA_W-1:0] r_lo;
    logic [mshl_pkg::DATA_W-1:0] r_hi;
    logic [mshl_pkg::DATA_W-1:0] n_lo;
    logic [mshl_pkg::DATA_W-1:0] n_hi;

    // A zero divisor makes every step succeed, so the quotient comes out all
    // ones and the remainder is the dividend magnitude; after the sign fix
    // that is exactly -1 or 1 in LO and the dividend in HI. The most negative
    // dividend over minus one wraps to the most negative value on its own.
    assign n_lo = i_work.q_neg ? mshl_pkg::negate(i_work.dq) : i_work.dq;
    assign n_hi = i_work.r_neg ? mshl_pkg::negate(i_work.rem) : i_work.rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

// ----- hdl/mips_signed_divide_hi_lo.sv -----
// Channel   Dir   Fields                Meaning
// i_op      in    dividend, divisor     signed 32-bit operands rs and rt
// o_res     out   quot_lo, rem_hi       LO and HI of the signed divide
//
// One word is accepted per cycle while the skid register is empty; each passes
// through the pipeline to o_res (one operand stage, 32 restoring steps of one
// quotient bit each, one sign stage). The 33-bit subtract of a step sets the
// stage depth. Reset is synchronous, active low, and empties the pipeline.
// A result that is not taken moves into a skid register; while it sits there
// the pipeline holds and i_op.ready is low.
`include "mips_signed_divide_hi_lo_assert.svh"

module mips_signed_divide_hi_lo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mshl_in_if.sink     i_op,
    mshl_out_if.source  o_res
);

    logic                            w_en;
    logic [mshl_pkg::STEPS:0]        w_valid;
    mshl_pkg::t_div_work             w_work [mshl_pkg::STEPS+1];
    logic                            w_post_valid;
    logic [mshl_pkg::DATA_W-1:0]     w_post_lo;
    logic [mshl_pkg::DATA_W-1:0]     w_post_hi;
    logic                            r_skid_valid;
    logic [mshl_pkg::DATA_W-1:0]     r_skid_lo;
    logic [mshl_pkg::DATA_W-1:0]     r_skid_hi;

    assign w_en       = !r_skid_valid;
    assign i_op.ready = w_en;

    mshl_pre u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_op.valid),
        .i_dividend (i_op.dividend),
        .i_divisor  (i_op.divisor),
        .o_valid    (w_valid[0]),
        .o_work     (w_work[0])
    );

    for (genvar g = 0; g < mshl_pkg::STEPS; g++) begin : g_step
        mshl_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_work  (w_work[g]),
            .o_valid (w_valid[g+1]),
            .o_work  (w_work[g+1])
        );
    end

    mshl_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[mshl_pkg::STEPS]),
        .i_work  (w_work[mshl_pkg::STEPS]),
        .o_valid (w_post_valid),
        .o_lo    (w_post_lo),
        .o_hi    (w_post_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en && w_post_valid && !o_res.ready) begin
            r_skid_valid <= 1'b1;
        end else if (r_skid_valid && o_res.ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_skid_lo <= w_post_lo;
            r_skid_hi <= w_post_hi;
        end
    end

    assign o_res.valid   = r_skid_valid || w_post_valid;
    assign o_res.quot_lo = r_skid_valid ? r_skid_lo : w_post_lo;
    assign o_res.rem_hi  = r_skid_valid ? r_skid_hi : w_post_hi;

    // The partial remainder after the last step stays below a nonzero divisor.
    `MSHL_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n, w_valid[mshl_pkg::STEPS] && (w_work[mshl_pkg::STEPS].dvs != '0), w_work[mshl_pkg::STEPS].rem < w_work[mshl_pkg::STEPS].dvs)
    // The skid register fills only from a stalled, valid final stage.
    `MSHL_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, !r_skid_valid && !(w_post_valid && !o_res.ready), !r_skid_valid)
    // A stalled skid word keeps the final stage's valid flag in place behind it.
    `MSHL_ASSERT_NEXT(a_hold_post, i_clk, i_rst_n, r_skid_valid && !o_res.ready, w_post_valid == $past(w_post_valid))

endmodule
